// ===== design/ycrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// ycrgb_pkg
// Shared constants and types for the YCbCr to RGB raster converter.
// ----------------------------------------------------------------------------
package ycrgb_pkg;

  localparam int COEFF_FRAC_BITS_DEF = 16;

  localparam int SAMPLE_W  = 11;
  localparam int BLOCK_W   = 26;
  localparam int PIXEL_W   = 6;
  localparam int DIM_W     = 16;
  localparam int COLOR_W   = 8;
  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 56;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 2'd2;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [BLOCK_W-1:0] block_index;
    logic [PIXEL_W-1:0] pixel_index;
  } pix_item_t;

endpackage

// ===== design/ycrgb_front.sv =====
// ----------------------------------------------------------------------------
// ycrgb_front
// Accepts pixels, scales the chroma terms and forms saturated RGB.
// ----------------------------------------------------------------------------
module ycrgb_front import ycrgb_pkg::*; #(
  parameter int COEFF_FRACTION_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] luma_value,
  input  logic signed [SAMPLE_W-1:0] blue_chroma,
  input  logic signed [SAMPLE_W-1:0] red_chroma,
  input  logic [BLOCK_W-1:0]         block_index,
  input  logic [PIXEL_W-1:0]         pixel_index,
  input  logic                       color_mode,
  output logic                       push,
  output pix_item_t                  push_item,
  input  logic                       queue_full
);

  localparam int F  = COEFF_FRACTION_BITS;
  localparam int QW = F + 1;
  localparam int PW = SAMPLE_W + QW + 1;
  localparam int SW = F + 14;
  localparam longint ONE = longint'(1) << F;
  localparam logic [QW-1:0] Q_CR_R = QW'((1402 * ONE + 500) / 1000);
  localparam logic [QW-1:0] Q_CB_G = QW'((34414 * ONE + 50000) / 100000);
  localparam logic [QW-1:0] Q_CR_G = QW'((71414 * ONE + 50000) / 100000);
  localparam logic [QW-1:0] Q_CB_B = QW'((1772 * ONE + 500) / 1000);

  function automatic logic [COLOR_W-1:0] sat(input logic signed [SW-1:0] s);
    if (s[SW-1]) begin
      sat = '0;
    end else if (|s[SW-2:F+8]) begin
      sat = '1;
    end else begin
      sat = s[F+7:F];
    end
  endfunction

  logic                 en;
  logic                 a_valid;
  logic                 b_valid;
  logic signed [11:0]   y12;
  logic signed [PW-1:0] m_cr_r, m_cb_g, m_cr_g, m_cb_b;
  logic signed [SW-1:0] base_a;
  logic signed [PW-1:0] p_cr_r, p_cb_g, p_cr_g, p_cb_b;
  logic [BLOCK_W-1:0]   blk_a;
  logic [PIXEL_W-1:0]   pix_a;
  logic signed [SW-1:0] s_r, s_g, s_b;

  assign en       = !b_valid || !queue_full;
  assign in_ready = en;
  assign push     = b_valid && !queue_full;

  assign y12    = {luma_value[SAMPLE_W-1], luma_value} + 12'sd128;
  assign m_cr_r = red_chroma  * $signed({1'b0, Q_CR_R});
  assign m_cb_g = blue_chroma * $signed({1'b0, Q_CB_G});
  assign m_cr_g = red_chroma  * $signed({1'b0, Q_CR_G});
  assign m_cb_b = blue_chroma * $signed({1'b0, Q_CB_B});

  // stage A: products; monochrome drops the chroma terms
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_a <= {{2{y12[11]}}, y12, {F{1'b0}}};
      p_cr_r <= color_mode ? m_cr_r : '0;
      p_cb_g <= color_mode ? m_cb_g : '0;
      p_cr_g <= color_mode ? m_cr_g : '0;
      p_cb_b <= color_mode ? m_cb_b : '0;
      blk_a  <= block_index;
      pix_a  <= pixel_index;
    end
  end

  assign s_r = base_a + SW'(p_cr_r);
  assign s_g = base_a - SW'(p_cb_g) - SW'(p_cr_g);
  assign s_b = base_a + SW'(p_cb_b);

  // stage B: sum, truncate, saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      push_item.red         <= sat(s_r);
      push_item.green       <= sat(s_g);
      push_item.blue        <= sat(s_b);
      push_item.block_index <= blk_a;
      push_item.pixel_index <= pix_a;
    end
  end

endmodule

// ===== design/ycrgb_queue.sv =====
// ----------------------------------------------------------------------------
// ycrgb_queue
// Short FIFO decoupling the color front end from the address back end.
// ----------------------------------------------------------------------------
module ycrgb_queue import ycrgb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pix_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output pix_item_t pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pix_item_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign do_pop   = pop && valid;
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/ycrgb_back.sv =====
// ----------------------------------------------------------------------------
// ycrgb_back
// Pipelined block-number divide, raster address, frame check, output reg.
// ----------------------------------------------------------------------------
module ycrgb_back import ycrgb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  pix_item_t             item,
  output logic                  pop,
  input  logic [DIM_W-1:0]      image_width,
  input  logic [DIM_W-1:0]      image_height,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COLOR_W-1:0]    red,
  output logic [COLOR_W-1:0]    green,
  output logic [COLOR_W-1:0]    blue,
  output logic [ADDR_W-1:0]     pixel_address,
  output logic                  in_frame
);

  localparam int NB    = BLOCK_W;
  localparam int XB_W  = DIM_W - 2;
  localparam int REM_W = DIM_W - 3;
  localparam int ROW_W = BLOCK_W + 3;

  logic                 adv;
  logic [DIM_W:0]       wsum;
  logic [XB_W-1:0]      xb_raw;
  logic [XB_W-1:0]      xb;

  logic                 dv   [NB];
  logic [REM_W-1:0]     drem [NB];
  logic [NB-1:0]        dnum [NB];
  pix_item_t            ditm [NB];

  logic [ROW_W-1:0]     row;
  logic [DIM_W-1:0]     col;
  logic [ROW_W+DIM_W-1:0] prod;

  logic                 mv;
  logic [ADDR_W-1:0]    mprod;
  logic [DIM_W-1:0]     mcol;
  logic                 mframe;
  pix_item_t            mitm;

  assign adv = !out_valid || out_ready;
  assign pop = adv && item_valid;

  // blocks per row, ceil(width/8), never zero
  assign wsum   = {1'b0, image_width} + (DIM_W+1)'(7);
  assign xb_raw = wsum[DIM_W:3];
  assign xb     = (xb_raw == '0) ? XB_W'(1) : xb_raw;

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < NB; i++) begin : g_div
    logic             v_in;
    logic [REM_W-1:0] r_in;
    logic [NB-1:0]    n_in;
    pix_item_t        itm_in;
    logic [XB_W-1:0]  t;
    logic [XB_W-1:0]  diff;
    logic             ge;

    if (i == 0) begin : g_head
      assign v_in   = item_valid;
      assign r_in   = '0;
      assign n_in   = item.block_index;
      assign itm_in = item;
    end else begin : g_link
      assign v_in   = dv[i-1];
      assign r_in   = drem[i-1];
      assign n_in   = dnum[i-1];
      assign itm_in = ditm[i-1];
    end

    assign t    = {r_in, n_in[NB-1]};
    assign ge   = (t >= xb);
    assign diff = t - xb;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i] <= 1'b0;
      end else if (adv) begin
        dv[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        drem[i] <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
        dnum[i] <= {n_in[NB-2:0], ge};
        ditm[i] <= itm_in;
      end
    end
  end

  assign row  = {dnum[NB-1], ditm[NB-1].pixel_index[5:3]};
  assign col  = {drem[NB-1], ditm[NB-1].pixel_index[2:0]};
  assign prod = row * image_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (adv) begin
      mv <= dv[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mprod  <= prod[ADDR_W-1:0];
      mcol   <= col;
      mframe <= (col < image_width) && (row < ROW_W'(image_height));
      mitm   <= ditm[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red           <= mitm.red;
      green         <= mitm.green;
      blue          <= mitm.blue;
      pixel_address <= mprod + ADDR_W'(mcol);
      in_frame      <= mframe;
    end
  end

endmodule

// ===== design/ycbcr_block_to_rgb_raster.sv =====
// ----------------------------------------------------------------------------
// ycbcr_block_to_rgb_raster
// YCbCr pixel to saturated RGB with raster address and in-frame flag.
//
// Input stream (s_*) carries one decoded pixel per beat: Y, Cb, Cr, the
// raster number of its 8x8 block and its index inside the block. Output
// stream (m_*) carries one RGB beat per input beat, in order, with the
// raster address in tdata and the in-frame flag in tuser.
// Configuration is a write-only port: cfg_we, cfg_index, cfg_data; write
// it only while no pixels are in flight. Index 3 is ignored.
// Throughput: one pixel per clock while m_tready is high. An input beat passes
// through the two color stages, the queue, the 26-stage block-number
// divider (one quotient bit per stage), the address multiply and the
// output register.
// Reset clears all valids and loads width 1, height 1, monochrome mode.
// When m_tready is low the back pipeline holds; the front fills the
// queue and then drops s_tready until beats drain.
// ----------------------------------------------------------------------------
module ycbcr_block_to_rgb_raster import ycrgb_pkg::*; #(
  parameter int COEFF_FRACTION_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // luma_value, blue_chroma, red_chroma, block_index, pixel_index, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // red, green, blue, pixel_address
  output logic [OUT_DATA_W-1:0] m_tdata,
  // in_frame
  output logic                  m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data
);

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic               color_mode;

  logic               push;
  pix_item_t          push_item;
  logic               queue_full;
  logic               q_valid;
  pix_item_t          q_item;
  logic               pop;

  logic [COLOR_W-1:0] red, green, blue;
  logic [ADDR_W-1:0]  pixel_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(1);
      image_height <= DIM_W'(1);
      color_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_COLOR_MODE:   color_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ycrgb_front #(
    .COEFF_FRACTION_BITS(COEFF_FRACTION_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .luma_value  ($signed(s_tdata[10:0])),
    .blue_chroma ($signed(s_tdata[21:11])),
    .red_chroma  ($signed(s_tdata[32:22])),
    .block_index (s_tdata[58:33]),
    .pixel_index (s_tdata[64:59]),
    .color_mode  (color_mode),
    .push        (push),
    .push_item   (push_item),
    .queue_full  (queue_full)
  );

  ycrgb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .valid     (q_valid),
    .pop_item  (q_item)
  );

  ycrgb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (q_valid),
    .item          (q_item),
    .pop           (pop),
    .image_width   (image_width),
    .image_height  (image_height),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .pixel_address (pixel_address),
    .in_frame      (m_tuser)
  );

  assign m_tdata = {pixel_address, blue, green, red};

endmodule

// ===== bench/rgb_raster_checker.sv =====
// ----------------------------------------------------------------------------
// rgb_raster_checker
// Predicts and checks every output beat of the YCbCr to RGB raster converter.
//
// Tracks the configuration port in shadow registers, converts each accepted
// input beat to its expected color, raster address and in-frame flag, and
// compares output beats in order against the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_raster_checker import ycrgb_pkg::*; #(
  parameter int COEFF_FRACTION_BITS = COEFF_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  output int                    mismatch_count,
  output int                    pending,
  output int                    beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_ONE     = longint'(1) << COEFF_FRACTION_BITS;
  localparam longint Q_CR_TO_R = (1402 * Q_ONE + 500) / 1000;
  localparam longint Q_CB_TO_G = (34414 * Q_ONE + 50000) / 100000;
  localparam longint Q_CR_TO_G = (71414 * Q_ONE + 50000) / 100000;
  localparam longint Q_CB_TO_B = (1772 * Q_ONE + 500) / 1000;

  typedef struct {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [ADDR_W-1:0]  addr;
    logic               in_frame;
  } raster_pixel_t;

  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic             color_q;

  raster_pixel_t expected_pixels[$];
  int            errs;
  int            checked;

  function automatic logic [COLOR_W-1:0] saturate(input longint s);
    longint q;
    if (s < 0) return '0;
    q = s / Q_ONE;
    return (q > 255) ? 8'd255 : q[COLOR_W-1:0];
  endfunction

  function automatic raster_pixel_t convert_pixel(input logic [IN_DATA_W-1:0] d);
    raster_pixel_t p;
    longint y, cb, cr, base;
    longint unsigned blk, pix, xb, col, row;
    y    = longint'($signed(d[SAMPLE_W-1:0]));
    cb   = longint'($signed(d[2*SAMPLE_W-1:SAMPLE_W]));
    cr   = longint'($signed(d[3*SAMPLE_W-1:2*SAMPLE_W]));
    blk  = d[3*SAMPLE_W +: BLOCK_W];
    pix  = d[3*SAMPLE_W+BLOCK_W +: PIXEL_W];
    base = (128 + y) * Q_ONE;
    xb   = (longint'(width_q) + 7) >> 3;
    if (xb == 0) xb = 1;
    col = (blk % xb) * 8 + (pix & 7);
    row = (blk / xb) * 8 + (pix >> 3);
    if (color_q) begin
      p.red   = saturate(base + cr * Q_CR_TO_R);
      p.green = saturate(base - cb * Q_CB_TO_G - cr * Q_CR_TO_G);
      p.blue  = saturate(base + cb * Q_CB_TO_B);
    end else begin
      p.red   = saturate(base);
      p.green = p.red;
      p.blue  = p.red;
    end
    p.addr     = ADDR_W'(row * width_q + col);
    p.in_frame = (col < width_q) && (row < height_q);
    return p;
  endfunction

  initial begin
    errs           = 0;
    checked        = 0;
    mismatch_count = 0;
    pending        = 0;
    beats_checked  = 0;
  end

  always @(posedge clk) begin
    raster_pixel_t got, want;
    if (rst) begin
      width_q  <= 16'd1;
      height_q <= 16'd1;
      color_q  <= 1'b0;
      expected_pixels.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.red      = m_tdata[7:0];
        got.green    = m_tdata[15:8];
        got.blue     = m_tdata[23:16];
        got.addr     = m_tdata[55:24];
        got.in_frame = m_tuser;
        checked++;
        if (expected_pixels.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("mismatch: unexpected beat r=%0d g=%0d b=%0d addr=%0h in_frame=%0b",
                     got.red, got.green, got.blue, got.addr, got.in_frame);
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.addr !== want.addr ||
              got.in_frame !== want.in_frame) begin
            errs++;
            if (errs <= 10) begin
              $display("mismatch: exp r=%0d g=%0d b=%0d addr=%0h in_frame=%0b",
                       want.red, want.green, want.blue, want.addr, want.in_frame);
              $display("          got r=%0d g=%0d b=%0d addr=%0h in_frame=%0b",
                       got.red, got.green, got.blue, got.addr, got.in_frame);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_pixels.push_back(convert_pixel(s_tdata));
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_q  <= cfg_data;
          REG_IMAGE_HEIGHT: height_q <= cfg_data;
          REG_COLOR_MODE:   color_q  <= cfg_data[0];
          default: ;
        endcase
      end
    end
    mismatch_count <= errs;
    beats_checked  <= checked;
    pending        <= rst ? 0 : expected_pixels.size();
  end

endmodule

// ===== bench/tb_ycbcr_block_to_rgb_raster.sv =====
// ----------------------------------------------------------------------------
// tb_ycbcr_block_to_rgb_raster
// Stimulus and verdict for the YCbCr to RGB raster converter.
//
// A directed set covers saturation extremes, both modes and frame edges, then
// random pixels run under a series of register settings, including zero
// width, zero height and full range, with varied input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_ycbcr_block_to_rgb_raster import ycrgb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES   = 64;
  localparam int NUM_SETTINGS   = 10;
  localparam int ITEMS_PER_SET  = 190;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [DIM_W-1:0]      cfg_data;

  int mismatch_count;
  int pending;
  int beats_checked;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int items_sent;
  int cur_width;
  int cur_height;

  int set_width  [NUM_SETTINGS] = '{640, 65535, 1, 0, 100, 8, 13, 0, 65535, 1};
  int set_height [NUM_SETTINGS] = '{480, 65535, 1, 37, 0, 8, 29, 0, 1, 65535};
  int set_color  [NUM_SETTINGS] = '{1, 1, 1, 1, 0, 0, 1, 1, 0, 1};

  ycbcr_block_to_rgb_raster uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  rgb_raster_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .pending       (pending),
    .beats_checked (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_pixel(input logic [SAMPLE_W-1:0] y,
      input logic [SAMPLE_W-1:0] cb, input logic [SAMPLE_W-1:0] cr,
      input logic [BLOCK_W-1:0] blk, input logic [PIXEL_W-1:0] pix);
    return {7'd0, pix, blk, cr, cb, y};
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 3))
      0: return SAMPLE_W'($urandom);
      1: return SAMPLE_W'(int'($urandom_range(0, 600)) - 300);
      2: return $urandom_range(0, 1) ? 11'h3FF : 11'h400;
      default: return SAMPLE_W'(int'($urandom_range(0, 255)) - 128);
    endcase
  endfunction

  function automatic logic [BLOCK_W-1:0] random_block(input int w, input int h);
    longint xb, yb, span;
    xb = (w + 7) >> 3;
    if (xb == 0) xb = 1;
    yb = (h + 7) >> 3;
    span = xb * yb + xb;
    if (span > 67108863) span = 67108863;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return BLOCK_W'($urandom_range(0, int'(span)));
      6, 7: return BLOCK_W'($urandom);
      8: return {BLOCK_W{1'b1}};
      default: return BLOCK_W'(span - $urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_pixel(input logic [IN_DATA_W-1:0] d);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic end_burst();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= DIM_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) cur_width = value;
    if (idx == REG_IMAGE_HEIGHT) cur_height = value;
  endtask

  task automatic set_pace(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default: begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  initial begin
    int w, h;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_IMAGE_WIDTH;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    items_sent     = 0;
    cur_width      = 1;
    cur_height     = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: 1x1 frame, monochrome
    send_pixel(pack_pixel(11'd0, 11'd0, 11'd0, 26'd0, 6'd0));
    send_pixel(pack_pixel(11'h3FF, 11'h155, 11'h2AA, 26'd0, 6'd1));
    send_pixel(pack_pixel(11'h400, 11'h3FF, 11'h400, 26'd1, 6'd63));
    send_pixel(pack_pixel(11'd127, 11'd0, 11'd0, 26'd0, 6'd8));
    send_pixel(pack_pixel(-11'sd128, 11'd0, 11'd0, 26'd0, 6'd0));
    send_pixel(pack_pixel(-11'sd129, 11'd0, 11'd0, 26'd0, 6'd0));
    end_burst();
    wait_drained();

    write_reg(REG_IMAGE_WIDTH, 20);
    write_reg(REG_IMAGE_HEIGHT, 12);
    write_reg(REG_COLOR_MODE, 1);
    send_pixel(pack_pixel(11'd0, 11'h400, 11'h3FF, 26'd0, 6'd0));
    send_pixel(pack_pixel(11'd0, 11'h3FF, 11'h400, 26'd1, 6'd9));
    send_pixel(pack_pixel(11'h400, 11'd0, 11'd0, 26'd2, 6'd3));
    send_pixel(pack_pixel(11'h3FF, 11'h3FF, 11'h3FF, 26'd2, 6'd7));
    send_pixel(pack_pixel(11'h400, 11'h400, 11'h400, 26'd3, 6'd0));
    send_pixel(pack_pixel(11'd127, 11'd0, 11'd0, 26'd5, 6'd56));
    send_pixel(pack_pixel(11'd10, 11'd20, -11'sd30, 26'h3FFFFFF, 6'd63));
    send_pixel(pack_pixel(-11'sd128, 11'd1, 11'd1, 26'd4, 6'd31));
    send_pixel(pack_pixel(11'd0, 11'd0, 11'd91, 26'd0, 6'd0));
    end_burst();
    wait_drained();

    write_reg(REG_COLOR_MODE, 0);
    write_reg(REG_SPARE, 1);
    send_pixel(pack_pixel(11'd5, 11'h3FF, 11'h400, 26'd0, 6'd0));
    send_pixel(pack_pixel(11'd5, 11'h400, 11'h3FF, 26'd1, 6'd10));
    send_pixel(pack_pixel(11'h3FF, 11'h2AA, 11'h155, 26'd6, 6'd40));
    send_pixel(pack_pixel(11'h400, 11'h155, 11'h2AA, 26'd8, 6'd0));
    end_burst();
    wait_drained();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      w = set_width[p];
      h = set_height[p];
      if (p == 7) begin
        w = $urandom_range(1, 65535);
        h = $urandom_range(1, 65535);
      end
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      write_reg(REG_COLOR_MODE, set_color[p]);
      set_pace(p);
      if (p == 0) hold_left = 400;
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        if (p == 2 && i == 95) begin
          end_burst();
          while (pending != 0) @(posedge clk);
        end
        send_pixel(pack_pixel(random_sample(), random_sample(), random_sample(),
                              random_block(cur_width, cur_height),
                              PIXEL_W'($urandom_range(0, 63))));
      end
      end_burst();
      wait_drained();
    end

    $display("covered %0d pixels, %0d beats checked, over %0d register settings",
             items_sent, beats_checked, NUM_SETTINGS + 3);
    $display("both modes, saturation extremes, zero width and height, frame edges, stalls");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
